/* rtl/pexp_pkg.sv */
package pexp_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_PALETTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORMAT = 2'd1;

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // output formats
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB444 = 1'b1;

    // result queue sizing
    localparam int unsigned OUTQ_DEPTH = 8;
    localparam int unsigned OUTQ_AW    = 3;
    localparam int unsigned OUTQ_CW    = 4;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  pixel_index;
        logic        last_pixel;
        logic [7:0]  palette_addr;
        logic [15:0] palette_word;
    } pexp_in_t;

    typedef struct packed {
        logic [15:0] out_value;
        logic        out_last;
    } pexp_out_t;

    // up to three results handed from the packer to the queue in one cycle
    typedef struct packed {
        logic [1:0]          cnt;
        pexp_out_t [2:0]     ent;
    } pexp_push_t;

    // byte-swapped rgb565 from 8-bit channels
    function automatic logic [15:0] swapped565(input logic [7:0] r,
                                                input logic [7:0] g,
                                                input logic [7:0] b);
        return {g[4:2], b[7:3], r[7:3], g[7:5]};
    endfunction

    // default 16-color palette in stored form
    function automatic logic [15:0] default_color(input logic [3:0] i);
        logic [15:0] c;
        unique case (i)
            4'd0:    c = swapped565(8'h00, 8'h00, 8'h00);
            4'd1:    c = swapped565(8'h00, 8'h00, 8'h00);
            4'd2:    c = swapped565(8'h21, 8'hC8, 8'h42);
            4'd3:    c = swapped565(8'h5E, 8'hDC, 8'h78);
            4'd4:    c = swapped565(8'h54, 8'h55, 8'hED);
            4'd5:    c = swapped565(8'h7D, 8'h76, 8'hFC);
            4'd6:    c = swapped565(8'hD4, 8'h52, 8'h4D);
            4'd7:    c = swapped565(8'h42, 8'hEB, 8'hF5);
            4'd8:    c = swapped565(8'hFC, 8'h55, 8'h54);
            4'd9:    c = swapped565(8'hFF, 8'h79, 8'h78);
            4'd10:   c = swapped565(8'hD4, 8'hC1, 8'h54);
            4'd11:   c = swapped565(8'hE6, 8'hCE, 8'h80);
            4'd12:   c = swapped565(8'h21, 8'hB0, 8'h3B);
            4'd13:   c = swapped565(8'hC9, 8'h5B, 8'hBA);
            4'd14:   c = swapped565(8'hCC, 8'hCC, 8'hCC);
            default: c = swapped565(8'hFF, 8'hFF, 8'hFF);
        endcase
        return c;
    endfunction

endpackage

/* rtl/palette_expand_rgb444_packer_core.sv */
// Indexed pixel expander with palette lookup and rgb444 pair packing.
// Input channel s_valid/s_ready/s_data carries either a pixel or a palette
// entry write; results leave on m_valid/m_ready/m_data, one 16-bit value
// per transfer with out_last on the final result of an item. Settings are
// written on the cfg channel (index 0 small palette mode, 1 output format);
// cfg_ready is always high and writing the format drops a pending half pair.
// A pixel transfer reads the palette RAM at its accept edge; its
// results enter the result queue at the following edge and can then be
// taken. Palette writes land at the accept edge and are seen by the
// very next pixel.
// Throughput: one item per cycle in rgb565 mode while the receiver
// takes every result; in rgb444 mode a pair of pixels yields three
// bytes, so the single-result-per-cycle output port sets the pace.
// The input is taken while the eight-entry result queue has room for the
// worst case of two items in flight, so a stalled receiver stops input
// after a few transfers and nothing is lost.
// Reset clears the queue, the pending half pair and the written flags of
// the palette; unwritten entries read the default 16 colors or zero.
module palette_expand_rgb444_packer_core #(
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pexp_pkg::pexp_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pexp_pkg::pexp_out_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [pexp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata
);
    import pexp_pkg::*;

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);

    logic                small_reg, fmt_reg;
    logic                held_clear;
    logic                s_xfer, pix_xfer, wr_xfer;
    logic [7:0]          idx;
    logic                idx_hit, wr_hit;
    logic [PALETTE_DEPTH-1:0] written_reg;
    logic [15:0]         ram_q;
    logic                s1_valid_reg, s1_last_reg, s1_hit_reg;
    logic                s1_written_reg, s1_low_reg;
    logic [3:0]          s1_nib_reg;
    logic [15:0]         s1_color;
    logic [OUTQ_CW-1:0]  level;
    pexp_push_t          push;

    assign cfg_ready = 1'b1;
    assign held_clear = cfg_valid && (cfg_index == CFG_OUTPUT_FORMAT);

    // room for this item plus the one ahead of it
    assign s_ready  = (level <= OUTQ_CW'(OUTQ_DEPTH - 6));
    assign s_xfer   = s_valid && s_ready;
    assign pix_xfer = s_xfer && (s_data.req_type == REQ_PIXEL);
    assign wr_xfer  = s_xfer && (s_data.req_type == REQ_WRITE) && wr_hit;

    // index masking and range checks
    assign idx     = small_reg ? {4'h0, s_data.pixel_index[3:0]} : s_data.pixel_index;
    assign idx_hit = ({1'b0, idx} < 9'(PALETTE_DEPTH));
    assign wr_hit  = ({1'b0, s_data.palette_addr} < 9'(PALETTE_DEPTH));

    pexp_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (wr_xfer),
        .waddr (s_data.palette_addr[AW-1:0]),
        .wdata (s_data.palette_word),
        .raddr (idx[AW-1:0]),
        .rdata (ram_q)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            small_reg <= 1'b1;
            fmt_reg   <= FMT_RGB565;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SMALL_PALETTE: small_reg <= cfg_wdata;
                CFG_OUTPUT_FORMAT: fmt_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-entry written flags, unwritten entries read their reset color
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_xfer) begin
            written_reg[s_data.palette_addr[AW-1:0]] <= 1'b1;
        end
    end

    // lookup stage alongside the ram read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= pix_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_xfer) begin
            s1_last_reg    <= s_data.last_pixel;
            s1_hit_reg     <= idx_hit;
            s1_written_reg <= idx_hit && written_reg[idx[AW-1:0]];
            s1_low_reg     <= (idx[7:4] == 4'h0);
            s1_nib_reg     <= idx[3:0];
        end
    end

    // color select: ram, default table or zero
    always_comb begin
        if (!s1_hit_reg) begin
            s1_color = 16'h0000;
        end else if (s1_written_reg) begin
            s1_color = ram_q;
        end else if (s1_low_reg) begin
            s1_color = default_color(s1_nib_reg);
        end else begin
            s1_color = 16'h0000;
        end
    end

    pexp_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix_valid  (s1_valid_reg),
        .pix_color  (s1_color),
        .pix_last   (s1_last_reg),
        .fmt        (fmt_reg),
        .held_clear (held_clear),
        .push       (push)
    );

    pexp_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .level   (level),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* rtl/pexp_ram.sv */
module pexp_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/pexp_pack.sv */
module pexp_pack (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pix_valid,
    input  logic [15:0]         pix_color,
    input  logic                pix_last,
    input  logic                fmt,
    input  logic                held_clear,
    output pexp_pkg::pexp_push_t push
);
    import pexp_pkg::*;

    logic        held_valid_reg, held_valid_next;
    logic [15:0] held_color_reg, held_color_next;
    logic [15:0] c1, c2;

    // colors back in plain rgb565 order
    assign c1 = {held_color_reg[7:0], held_color_reg[15:8]};
    assign c2 = {pix_color[7:0], pix_color[15:8]};

    // pair packing and word pass-through
    always_comb begin
        held_valid_next = held_valid_reg;
        held_color_next = held_color_reg;
        push.cnt        = 2'd0;
        push.ent        = '0;
        if (held_clear) begin
            held_valid_next = 1'b0;
        end else if (pix_valid) begin
            if (fmt == FMT_RGB565) begin
                push.cnt                 = 2'd1;
                push.ent[0].out_value    = pix_color;
                push.ent[0].out_last     = 1'b1;
            end else if (!held_valid_reg && !pix_last) begin
                held_valid_next = 1'b1;
                held_color_next = pix_color;
            end else if (!held_valid_reg) begin
                // odd flush, second pixel padded with zero
                push.cnt                 = 2'd3;
                push.ent[0].out_value    = {8'h00, c2[15:12], c2[10:7]};
                push.ent[1].out_value    = {8'h00, c2[4:1], 4'h0};
                push.ent[2].out_value    = 16'h0000;
                push.ent[2].out_last     = 1'b1;
            end else begin
                held_valid_next = 1'b0;
                push.cnt                 = 2'd3;
                push.ent[0].out_value    = {8'h00, c1[15:12], c1[10:7]};
                push.ent[1].out_value    = {8'h00, c1[4:1], c2[15:12]};
                push.ent[2].out_value    = {8'h00, c2[10:7], c2[4:1]};
                push.ent[2].out_last     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_color_reg <= 16'h0000;
        end else begin
            held_valid_reg <= held_valid_next;
            held_color_reg <= held_color_next;
        end
    end

endmodule

/* rtl/pexp_outq.sv */
module pexp_outq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pexp_pkg::pexp_push_t push,
    output logic [pexp_pkg::OUTQ_CW-1:0] level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pexp_pkg::pexp_out_t  m_data
);
    import pexp_pkg::*;

    pexp_out_t            q_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wptr_reg, rptr_reg;
    logic [OUTQ_CW-1:0]   cnt_reg, cnt_next;
    logic                 pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (cnt_reg != '0);
    assign m_data   = q_reg[rptr_reg];
    assign level    = cnt_reg;
    assign cnt_next = cnt_reg + OUTQ_CW'(push.cnt) - OUTQ_CW'(pop);

    // multi-entry write, one read per transfer
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (k < int'(push.cnt)) begin
                q_reg[wptr_reg + OUTQ_AW'(k)] <= push.ent[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_reg + OUTQ_AW'(push.cnt);
            rptr_reg <= rptr_reg + OUTQ_AW'(pop);
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* rtl/pexp_chk.sv */
module pexp_chk (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input pexp_pkg::pexp_out_t  m_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);
    import pexp_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing pending and input open right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid && s_ready)
        else $error("queue not empty after reset");

    // settings are always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // no result can appear unless an item was taken through the lookup stage ahead of it
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(m_valid) && m_valid |-> $past(s_valid && s_ready, 2))
        else $error("result without a pixel transfer");

endmodule

bind palette_expand_rgb444_packer_core pexp_chk u_pexp_chk (.*);

/* test/tb_palette_expand_rgb444_packer_core.sv */
`timescale 1ns / 1ps

module tb_palette_expand_rgb444_packer_core;

    import pexp_pkg::*;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;

    // default colors as 8-bit r,g,b, entry 15 first
    localparam logic [16*24-1:0] DEF_RGB = {
        24'hFFFFFF, 24'hCCCCCC, 24'hC95BBA, 24'h21B03B,
        24'hE6CE80, 24'hD4C154, 24'hFF7978, 24'hFC5554,
        24'h42EBF5, 24'hD4524D, 24'h7D76FC, 24'h5455ED,
        24'h5EDC78, 24'h21C842, 24'h000000, 24'h000000
    };

    logic aclk;
    logic aresetn = 1'b0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    pexp_in_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    pexp_out_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic                   cfg_wdata = 1'b0;

    palette_expand_rgb444_packer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predicted block state
    logic [15:0] palette_mem [256];
    logic [15:0] pair_first;
    logic        pair_pending;
    logic        mode_small;
    logic        mode_fmt;

    pexp_in_t  pixel_pend_q [$];
    pexp_out_t color_expect_q [$];
    pexp_out_t want;

    logic s_hs = 1'b0;
    logic cfg_hs = 1'b0;
    logic idle_en = 1'b1;
    int   err_count = 0;
    int   stall_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic reset_model();
        logic [23:0] rgb;
        for (int i = 0; i < 256; i++) palette_mem[i] = '0;
        // stored form: g[4:2], b[7:3] in the high byte, r[7:3], g[7:5] in the low byte
        for (int i = 0; i < 16; i++) begin
            rgb = DEF_RGB[i*24 +: 24];
            palette_mem[i] = {rgb[12:10], rgb[7:3], rgb[23:19], rgb[15:13]};
        end
        pair_first   = '0;
        pair_pending = 1'b0;
        mode_small   = 1'b1;
        mode_fmt     = FMT_RGB565;
    endtask

    task automatic push_color(input logic [15:0] value, input logic last);
        pexp_out_t r;
        r.out_value = value;
        r.out_last  = last;
        color_expect_q.push_back(r);
    endtask

    // expected results of one accepted item
    task automatic predict_item(input pexp_in_t it);
        logic [7:0]  idx;
        logic [15:0] col;
        logic [15:0] c1;
        logic [15:0] c2;
        if (it.req_type == REQ_WRITE) begin
            palette_mem[it.palette_addr] = it.palette_word;
        end else begin
            idx = mode_small ? {4'h0, it.pixel_index[3:0]} : it.pixel_index;
            col = palette_mem[idx];
            if (mode_fmt == FMT_RGB565) begin
                push_color(col, 1'b1);
            end else if (!pair_pending && !it.last_pixel) begin
                pair_first   = col;
                pair_pending = 1'b1;
            end else begin
                // back to plain rgb565; an odd flush pairs with black
                c1 = pair_pending ? {pair_first[7:0], pair_first[15:8]} : {col[7:0], col[15:8]};
                c2 = pair_pending ? {col[7:0], col[15:8]} : 16'h0000;
                pair_pending = 1'b0;
                push_color({8'h00, c1[15:12], c1[10:7]}, 1'b0);
                push_color({8'h00, c1[4:1], c2[15:12]}, 1'b0);
                push_color({8'h00, c2[10:7], c2[4:1]}, 1'b1);
            end
        end
    endtask

    task automatic predict_cfg(input logic [CFG_IDX_W-1:0] idx, input logic d);
        case (idx)
            CFG_SMALL_PALETTE: mode_small = d;
            CFG_OUTPUT_FORMAT: begin
                mode_fmt     = d;
                pair_pending = 1'b0;
            end
            default: ;
        endcase
    endtask

    // input and result driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_hs) begin
                if (pixel_pend_q.size() > 0 && !(idle_en && $urandom_range(99) < 28)) begin
                    s_data  <= pixel_pend_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= idle_en ? ($urandom_range(99) >= 28) : 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin
        s_hs   <= aresetn && s_valid && s_ready;
        cfg_hs <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (s_valid && s_ready) predict_item(s_data);
            if (cfg_valid && cfg_ready) predict_cfg(cfg_index, cfg_wdata);
            if (m_valid && m_ready) begin
                if (color_expect_q.size() == 0) begin
                    report($sformatf("unexpected result value %h last %b",
                                     m_data.out_value, m_data.out_last));
                end else begin
                    want = color_expect_q.pop_front();
                    if (m_data.out_value !== want.out_value)
                        report($sformatf("out_value %h, want %h",
                                         m_data.out_value, want.out_value));
                    if (m_data.out_last !== want.out_last)
                        report($sformatf("out_last %b, want %b",
                                         m_data.out_last, want.out_last));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cnt <= 0;
            end else if (stall_cnt >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    function automatic pexp_in_t pixel_item(input logic [7:0] idx, input logic last);
        pexp_in_t it;
        it.req_type     = REQ_PIXEL;
        it.pixel_index  = idx;
        it.last_pixel   = last;
        it.palette_addr = 8'($urandom);
        it.palette_word = 16'($urandom);
        return it;
    endfunction

    function automatic pexp_in_t write_item(input logic [7:0] addr, input logic [15:0] word);
        pexp_in_t it;
        it.req_type     = REQ_WRITE;
        it.pixel_index  = 8'($urandom);
        it.last_pixel   = 1'($urandom);
        it.palette_addr = addr;
        it.palette_word = word;
        return it;
    endfunction

    // wait until every queued item is taken and every result is in;
    // checked at the rising edge, where the driver's outputs are settled
    task automatic drain();
        while (pixel_pend_q.size() > 0 || s_valid || color_expect_q.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        do @(negedge aclk); while (!cfg_hs);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        pexp_in_t it;
        reset_model();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: masked index, rgb565 words
        pixel_pend_q.push_back(pixel_item(8'h00, 1'b0));
        pixel_pend_q.push_back(pixel_item(8'h0F, 1'b1));
        pixel_pend_q.push_back(pixel_item(8'hFF, 1'b0));
        pixel_pend_q.push_back(pixel_item(8'h10, 1'b1));
        pixel_pend_q.push_back(write_item(8'hFF, 16'hFFFF));
        pixel_pend_q.push_back(write_item(8'h80, 16'h5AA5));
        pixel_pend_q.push_back(write_item(8'h00, 16'h0000));
        drain();

        // full index: written and never-written entries
        write_reg(CFG_SMALL_PALETTE, 1'b0);
        pixel_pend_q.push_back(pixel_item(8'hFF, 1'b1));
        pixel_pend_q.push_back(pixel_item(8'h80, 1'b0));
        pixel_pend_q.push_back(pixel_item(8'h7F, 1'b0));
        drain();

        // rgb444: pair ending on last, plain pair, odd flush, then a held pixel
        write_reg(CFG_OUTPUT_FORMAT, FMT_RGB444);
        pixel_pend_q.push_back(pixel_item(8'h02, 1'b0));
        pixel_pend_q.push_back(pixel_item(8'h03, 1'b1));
        pixel_pend_q.push_back(pixel_item(8'hFF, 1'b0));
        pixel_pend_q.push_back(pixel_item(8'h09, 1'b0));
        pixel_pend_q.push_back(pixel_item(8'h05, 1'b1));
        pixel_pend_q.push_back(pixel_item(8'h0C, 1'b0));
        drain();

        // mode change keeps the held pixel
        write_reg(CFG_SMALL_PALETTE, 1'b1);
        pixel_pend_q.push_back(pixel_item(8'hFD, 1'b1));
        pixel_pend_q.push_back(pixel_item(8'h0E, 1'b0));
        drain();

        // format write drops the held half pair
        write_reg(CFG_OUTPUT_FORMAT, FMT_RGB444);
        pixel_pend_q.push_back(pixel_item(8'h04, 1'b1));
        drain();

        // spare indexes leave everything alone
        write_reg(CFG_SPARE_LO, 1'b1);
        write_reg(CFG_SPARE_HI, 1'b0);
        write_reg(CFG_SPARE_LO, 1'b0);
        write_reg(CFG_SPARE_HI, 1'b1);
        pixel_pend_q.push_back(pixel_item(8'h01, 1'b1));
        drain();

        // random phases, the second without idling
        for (int ph = 0; ph < 4; ph++) begin
            idle_en = (ph != 1);
            write_reg(CFG_SMALL_PALETTE, 1'($urandom));
            if (ph == 0 || $urandom_range(3) != 0)
                write_reg(CFG_OUTPUT_FORMAT, (ph == 0) ? FMT_RGB565 : 1'($urandom));
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 1'($urandom));
            for (int n = 0; n < 35; n++) begin
                if ($urandom_range(99) < 15)
                    it = write_item($urandom_range(2) == 0 ? 8'($urandom_range(15)) : 8'($urandom),
                                    16'($urandom));
                else
                    it = pixel_item(8'($urandom), $urandom_range(99) < 25);
                pixel_pend_q.push_back(it);
            end
            drain();
        end

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
